// ----- rtl/lruc_pkg.sv -----
// Package with shared types, constants and helpers of the LRU cache tag store.
package lruc_pkg;

    localparam int SBITS_MAX = 12;
    localparam int RANK_W = 3;
    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
    localparam int CNT_W = 32;

    localparam logic [1:0] MODE_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_WAYS = 2'd1;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic clr_we;
        logic load_in;
        logic decode;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/lruc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/lruc_ctrl.sv -----
// Controller state machine that sequences clearing, decode, tag read and update.
module lruc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lruc_pkg::status_t  status,
    output lruc_pkg::cmd_t     cmd
);

    lruc_pkg::state_t state_reg;
    lruc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lruc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lruc_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = lruc_pkg::ST_IDLE;
                end
            end
            lruc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lruc_pkg::ST_DECODE;
                end
            end
            lruc_pkg::ST_DECODE: state_next = lruc_pkg::ST_READ;
            lruc_pkg::ST_READ:   state_next = lruc_pkg::ST_LOOKUP;
            lruc_pkg::ST_LOOKUP:
            begin
                if (status.out_free)
                begin
                    state_next = lruc_pkg::ST_IDLE;
                end
            end
            default: state_next = lruc_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lruc_pkg::ST_CLEAR:  cmd.clr_we = 1'b1;
            lruc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_in = in_valid;
            end
            lruc_pkg::ST_DECODE: cmd.decode = 1'b1;
            lruc_pkg::ST_READ:   cmd.rd_en = 1'b1;
            lruc_pkg::ST_LOOKUP: cmd.commit = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- rtl/lruc_dp.sv -----
// Datapath: configuration, address decode, tag RAM, way selection, counters, output.
module lruc_dp #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic [63:0]        in_address,
    input  logic [1:0]         in_mode,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [103:0]       out_data,
    input  lruc_pkg::cmd_t     cmd,
    output lruc_pkg::status_t  status
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W = ADDR_WIDTH + lruc_pkg::RANK_W + 1;
    localparam int ROW_W = MAX_WAYS * WAY_W;
    localparam logic [24:0] RECIP = 25'((1 << 24) / MAX_SETS);
    localparam logic [12:0] NSETS = 13'(MAX_SETS);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);
    localparam logic [4:0] MAXW = 5'(MAX_WAYS);
    localparam int CW = lruc_pkg::CNT_W;
    localparam int RW = lruc_pkg::RANK_W;

    logic [3:0] sbits_cfg_reg, ways_cfg_reg, obits_cfg_reg;
    logic [ADDR_WIDTH-1:0] addr_reg, tag_reg;
    logic [1:0] mode_reg;
    logic [11:0] x_reg, q_reg;
    logic [SET_W-1:0] set_reg, clr_addr_reg, set_next;
    logic [CW-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [CW-1:0] hit_cnt_next, miss_cnt_next, evict_cnt_next;
    logic out_valid_reg;
    logic [2:0] flags_reg;

    logic [3:0] sbits, obits;
    logic [4:0] ways;
    logic [ADDR_WIDTH-1:0] shifted, tag_calc;
    logic [11:0] x_calc;
    logic [36:0] prod;
    logic [24:0] qn;
    logic [12:0] rem;

    logic [ROW_W-1:0] rdata, wdata, row_new;
    logic ram_we;
    logic [SET_W-1:0] waddr;

    logic [MAX_WAYS-1:0] v;
    logic [RW-1:0] rk [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] tg [MAX_WAYS];
    logic hit, free_found, evict, was_valid;
    logic [WAY_IW-1:0] hit_w, free_w, vict_w, w;
    logic [RW-1:0] best, r;

    // Set-bit and way register values clamped to what the lookup supports; offset bits pass through.
    always_comb
    begin
        sbits = (sbits_cfg_reg > 4'(lruc_pkg::SBITS_MAX)) ? 4'(lruc_pkg::SBITS_MAX)
                                                          : sbits_cfg_reg;
        obits = obits_cfg_reg;
        ways = (ways_cfg_reg == 4'd0) ? 5'd1 : 5'(ways_cfg_reg);
        if (ways > MAXW)
        begin
            ways = MAXW;
        end
    end

    // The set number is reduced modulo the set count by reciprocal multiply.
    always_comb
    begin
        shifted = addr_reg >> obits;
        x_calc = 12'(shifted) & 12'((13'd1 << sbits) - 13'd1);
        tag_calc = addr_reg >> (5'(obits) + 5'(sbits));
        prod = 37'(x_calc) * 37'(RECIP);
        qn = 25'(q_reg) * 25'(NSETS);
        rem = 13'(25'(x_reg) - qn);
        if (rem >= NSETS)
        begin
            rem = rem - NSETS;
        end
        set_next = SET_W'(rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbits_cfg_reg <= 4'd4;
            ways_cfg_reg <= 4'd1;
            obits_cfg_reg <= 4'd4;
            clr_addr_reg <= '0;
            hit_cnt_reg <= '0;
            miss_cnt_reg <= '0;
            evict_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lruc_pkg::CFG_SET_BITS:    sbits_cfg_reg <= cfg_data;
                    lruc_pkg::CFG_WAYS:        ways_cfg_reg <= cfg_data;
                    lruc_pkg::CFG_OFFSET_BITS: obits_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr_we)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                hit_cnt_reg <= hit_cnt_next;
                miss_cnt_reg <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            addr_reg <= in_address[ADDR_WIDTH-1:0];
            mode_reg <= in_mode;
        end
        if (cmd.decode)
        begin
            x_reg <= x_calc;
            tag_reg <= tag_calc;
        end
        if (cmd.decode)
        begin
            q_reg <= 12'(prod >> 24);
        end
        if (cmd.rd_en)
        begin
            set_reg <= set_next;
        end
        if (cmd.commit)
        begin
            flags_reg <= {evict, ~hit, hit};
        end
    end

    assign ram_we = cmd.clr_we | cmd.commit;
    assign waddr = cmd.clr_we ? clr_addr_reg : set_reg;
    assign wdata = cmd.clr_we ? '0 : row_new;

    lruc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_SETS)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(waddr),
        .wdata(wdata),
        .re(cmd.rd_en),
        .raddr(set_next),
        .rdata(rdata)
    );

    // Way lookup, replacement choice and age update of the selected set.
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            v[i] = rdata[i*WAY_W];
            rk[i] = rdata[i*WAY_W+1 +: RW];
            tg[i] = rdata[i*WAY_W+1+RW +: ADDR_WIDTH];
        end
        hit = 1'b0;
        free_found = 1'b0;
        hit_w = '0;
        free_w = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (5'(i) < ways && v[i] && tg[i] == tag_reg)
            begin
                hit = 1'b1;
                hit_w = WAY_IW'(i);
            end
            if (5'(i) < ways && !v[i])
            begin
                free_found = 1'b1;
                free_w = WAY_IW'(i);
            end
        end
        best = '0;
        vict_w = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (5'(i) < ways && rk[i] > best)
            begin
                best = rk[i];
                vict_w = WAY_IW'(i);
            end
        end
        evict = !hit && !free_found;
        w = hit ? hit_w : (free_found ? free_w : vict_w);
        r = rk[w];
        was_valid = v[w];
        row_new = rdata;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_IW'(i) == w)
            begin
                row_new[i*WAY_W +: WAY_W] = {tag_reg, {RW{1'b0}}, 1'b1};
            end
            else if (5'(i) < ways && v[i] && (!was_valid || rk[i] < r)
                     && rk[i] != lruc_pkg::RANK_MAX)
            begin
                row_new[i*WAY_W+1 +: RW] = rk[i] + 1'b1;
            end
        end
        hit_cnt_next = hit ? lruc_pkg::sat_inc(hit_cnt_reg) : hit_cnt_reg;
        if (mode_reg == lruc_pkg::MODE_MODIFY)
        begin
            hit_cnt_next = lruc_pkg::sat_inc(hit_cnt_next);
        end
        miss_cnt_next = hit ? miss_cnt_reg : lruc_pkg::sat_inc(miss_cnt_reg);
        evict_cnt_next = evict ? lruc_pkg::sat_inc(evict_cnt_reg) : evict_cnt_reg;
    end

    assign status.clear_last = (clr_addr_reg == LAST_SET);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = {5'd0, evict_cnt_reg, miss_cnt_reg, hit_cnt_reg, flags_reg};

endmodule

// ----- rtl/lru_set_assoc_cache_tags.sv -----
// Top level of the set-associative cache tag store with LRU replacement.
//
// Channel  Direction  Beat contents
// s_axis   in         tdata: address; tuser: mode
// m_axis   out        tdata: hit, miss, eviction flags and three running totals
// cfg      in         one register write per cycle with cfg_we high
//
// An access steps through accept, address decode with the reciprocal multiply,
// the set-number reduction with the registered read of the set's row, then
// lookup and write-back. After reset a clearing pass writes every set row once
// with s_axis_tready low. A result waiting on m_axis holds the write-back of the
// following access until it is taken.
module lru_set_assoc_cache_tags #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // address[63:0]
    input  logic [1:0]   s_axis_tuser,   // mode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // was_hit, was_miss, was_eviction, hit_total, miss_total, eviction_total
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [3:0]   cfg_data
);

    lruc_pkg::cmd_t cmd;
    lruc_pkg::status_t status;

    lruc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .status(status),
        .cmd(cmd)
    );

    lruc_dp #(
        .MAX_SETS(MAX_SETS),
        .MAX_WAYS(MAX_WAYS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_address(s_axis_tdata),
        .in_mode(s_axis_tuser),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data(m_axis_tdata),
        .cmd(cmd),
        .status(status)
    );

endmodule

// ----- rtl/lruc_checker.sv -----
// Port checker for the cache tag store and its bind to the top level.
module lruc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] ^ m_axis_tdata[1]))
        else $error("result is not exactly one of hit and miss");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("eviction without a miss");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted while an access is in flight");

endmodule

bind lru_set_assoc_cache_tags lruc_checker u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
